/* rtl/core/hsfd_pkg.sv */
// ----------------------------------------------------------------------------
// hsfd_pkg: shared types, constants and functions of the frame decoder
// Holds the CRC-8 byte update, the divide-by-65535 helper, the frame record
// passed from the front end to the back end, and the queue sizing.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    // CRC-8 settings of the sensor reply.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Scaling constants.
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [15:0] RAW_FULL    = 16'hFFFF;
    localparam logic signed [15:0] TEMP_OFFSET = -16'sd4500;

    // Byte positions inside one six-byte frame.
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Frame status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Queue between the front end and the back end.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One complete frame, ready for scaling.
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic        crc_err;
    } frame_t;

    // One byte of MSB-first CRC-8, no reflection, no final XOR.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 65535 * 65536. The quotient estimate
    // x >> 16 is low by at most one; the remainder then stays below twice
    // the divisor, so one compare fixes it.
    function automatic logic [15:0] div_full(input logic [31:0] x);
        logic [15:0] q0;
        logic [16:0] r;
        q0 = x[31:16];
        r  = {1'b0, x[15:0]} + {1'b0, q0};
        if (r >= {1'b0, RAW_FULL})
            return q0 + 16'd1;
        else
            return q0;
    endfunction

endpackage

/* rtl/core/humidity_sensor_frame_decoder.sv */
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder: sensor reply decoder, top level
// Checks the two CRC-8 words of each six-byte reply and scales the raw
// temperature and humidity into hundredths.
// ----------------------------------------------------------------------------
// The block takes one reply byte per clock cycle on the input channel
// while tready is high and delivers one result word for every six bytes
// through the frame queue, the product stage and the output register.
// Input tready drops only when the two-entry frame queue is full, which
// happens only after the output side has stalled for about three frames;
// the frame queue lets new bytes in while a result waits. Input tuser
// marks the first byte of a frame and restarts the byte count; output
// tuser is the frame status (1 on a CRC mismatch, with both values zero).
module humidity_sensor_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] rx_byte
    input  logic        s_tuser,  // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi
    output logic        m_tuser   // [0] frame_status
);

    logic             byte_valid;
    logic             push;
    hsfd_pkg::frame_t push_data;
    logic             q_full;
    logic             q_not_empty;
    logic             q_pop;
    hsfd_pkg::frame_t q_data;
    logic [14:0]      temperature_centi;
    logic [13:0]      humidity_centi;
    logic             frame_status;

    assign s_tready   = !q_full;
    assign byte_valid = s_tvalid && s_tready;

    // Byte tracking and CRC check.
    hsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .push        (push),
        .push_data   (push_data)
    );

    // Frame queue.
    hsfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    // Scaling pipeline.
    hsfd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .job_valid         (q_not_empty),
        .job               (q_data),
        .job_pop           (q_pop),
        .res_valid         (m_tvalid),
        .res_ready         (m_tready),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .frame_status      (frame_status)
    );

    assign m_tdata = {3'b000, humidity_centi, temperature_centi};
    assign m_tuser = frame_status;

    // An error result carries zero values.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata == 32'd0)
        else $error("error result with nonzero values");

    // Temperature stays within the sensor span.
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |->
            ($signed(m_tdata[14:0]) >= -15'sd4500 && $signed(m_tdata[14:0]) <= 15'sd13000))
        else $error("temperature out of range");

    // Humidity stays within the sensor span; the pad bits stay zero.
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[28:15] <= 14'd10000 && m_tdata[31:29] == 3'b000))
        else $error("humidity out of range");

endmodule

/* rtl/core/hsfd_front.sv */
// ----------------------------------------------------------------------------
// hsfd_front: byte tracker and CRC checker
// Follows the byte position, runs the CRC of each two-byte word, assembles
// the raw words and hands a frame record over after the sixth byte.
// ----------------------------------------------------------------------------
module hsfd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    input  logic [7:0]      rx_byte,
    input  logic            frame_start,
    output logic            push,
    output hsfd_pkg::frame_t push_data
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] tword_reg, tword_next;
    logic        tgood_reg, tgood_next;
    logic [15:0] hword_reg, hword_next;
    logic [2:0]  pos_eff;
    logic [7:0]  crc_eff;
    logic [7:0]  crc_upd;
    logic        hgood;

    // A start flag or an unused position restarts the frame.
    always_comb
    begin
        pos_eff = pos_reg;
        crc_eff = crc_reg;
        if (frame_start || pos_reg > hsfd_pkg::POS_H_CRC)
        begin
            pos_eff = hsfd_pkg::POS_T_HI;
            crc_eff = hsfd_pkg::CRC_INIT;
        end
    end

    assign crc_upd = hsfd_pkg::crc8_byte(crc_eff, rx_byte);
    assign hgood   = (crc_eff == rx_byte);

    // Next state for one accepted byte.
    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        tword_next = tword_reg;
        tgood_next = tgood_reg;
        hword_next = hword_reg;
        push       = 1'b0;
        if (byte_valid)
        begin
            case (pos_eff)
                hsfd_pkg::POS_T_HI:
                begin
                    crc_next   = crc_upd;
                    tword_next = {rx_byte, 8'h00};
                    pos_next   = hsfd_pkg::POS_T_LO;
                end
                hsfd_pkg::POS_T_LO:
                begin
                    crc_next   = crc_upd;
                    tword_next = {tword_reg[15:8], rx_byte};
                    pos_next   = hsfd_pkg::POS_T_CRC;
                end
                hsfd_pkg::POS_T_CRC:
                begin
                    tgood_next = (crc_eff == rx_byte);
                    crc_next   = hsfd_pkg::CRC_INIT;
                    pos_next   = hsfd_pkg::POS_H_HI;
                end
                hsfd_pkg::POS_H_HI:
                begin
                    crc_next   = crc_upd;
                    hword_next = {rx_byte, 8'h00};
                    pos_next   = hsfd_pkg::POS_H_LO;
                end
                hsfd_pkg::POS_H_LO:
                begin
                    crc_next   = crc_upd;
                    hword_next = {hword_reg[15:8], rx_byte};
                    pos_next   = hsfd_pkg::POS_H_CRC;
                end
                default:
                begin
                    crc_next = hsfd_pkg::CRC_INIT;
                    pos_next = hsfd_pkg::POS_T_HI;
                    push     = 1'b1;
                end
            endcase
        end
    end

    // Frame record for the queue.
    always_comb
    begin
        push_data.temp_word = tword_reg;
        push_data.hum_word  = hword_reg;
        push_data.crc_err   = !(tgood_reg && hgood);
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= hsfd_pkg::POS_T_HI;
            crc_reg   <= hsfd_pkg::CRC_INIT;
            tword_reg <= '0;
            tgood_reg <= 1'b0;
            hword_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            tword_reg <= tword_next;
            tgood_reg <= tgood_next;
            hword_reg <= hword_next;
        end
    end

endmodule

/* rtl/core/hsfd_queue.sv */
// ----------------------------------------------------------------------------
// hsfd_queue: small frame queue
// Holds finished frame records so the front end and the back end stall
// independently of each other.
// ----------------------------------------------------------------------------
module hsfd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hsfd_pkg::frame_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output hsfd_pkg::frame_t pop_data
);

    hsfd_pkg::frame_t mem [hsfd_pkg::Q_DEPTH];
    logic [hsfd_pkg::Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [hsfd_pkg::Q_CW-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full      = (count_reg == hsfd_pkg::Q_CW'(hsfd_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    // Occupancy update.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == hsfd_pkg::Q_AW'(hsfd_pkg::Q_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == hsfd_pkg::Q_AW'(hsfd_pkg::Q_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // A frame arriving at a full queue would be lost.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("frame pushed into a full queue");

    // The count steps up by one on a push without a pop.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

/* rtl/core/hsfd_back.sv */
// ----------------------------------------------------------------------------
// hsfd_back: scaling pipeline
// Stage one multiplies the raw words by their spans, stage two divides by
// the full-scale value, adds the temperature offset and holds the result
// word for the output channel.
// ----------------------------------------------------------------------------
module hsfd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  hsfd_pkg::frame_t job,
    output logic             job_pop,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [14:0]      temperature_centi,
    output logic [13:0]      humidity_centi,
    output logic             frame_status
);

    logic        s1_valid_reg;
    logic [30:0] s1_tprod_reg;
    logic [29:0] s1_hprod_reg;
    logic        s1_err_reg;
    logic        out_valid_reg;
    logic [14:0] temp_reg;
    logic [13:0] hum_reg;
    logic        status_reg;
    logic        out_free;
    logic        s1_take;
    logic [15:0] temp_q;
    logic [15:0] hum_q;
    logic signed [15:0] temp_val;

    // Pipeline flow: the output register frees when its word is taken.
    assign out_free = !out_valid_reg || res_ready;
    assign s1_take  = !s1_valid_reg || out_free;
    assign job_pop  = job_valid && s1_take;

    // Stage two arithmetic.
    assign temp_q   = hsfd_pkg::div_full({1'b0, s1_tprod_reg});
    assign hum_q    = hsfd_pkg::div_full({2'b00, s1_hprod_reg});
    assign temp_val = $signed(temp_q) + hsfd_pkg::TEMP_OFFSET;

    // Stage one: products.
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            s1_tprod_reg <= 31'(job.temp_word) * 31'(hsfd_pkg::TEMP_SPAN);
            s1_hprod_reg <= 30'(job.hum_word) * 30'(hsfd_pkg::HUM_SPAN);
            s1_err_reg   <= job.crc_err;
        end
    end

    // Stage two: result word, zeroed on a checksum mismatch.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_free)
        begin
            if (s1_err_reg)
            begin
                temp_reg   <= '0;
                hum_reg    <= '0;
                status_reg <= hsfd_pkg::STATUS_ERR;
            end
            else
            begin
                temp_reg   <= temp_val[14:0];
                hum_reg    <= hum_q[13:0];
                status_reg <= hsfd_pkg::STATUS_OK;
            end
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
                s1_valid_reg <= job_pop;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign res_valid         = out_valid_reg;
    assign temperature_centi = temp_reg;
    assign humidity_centi    = hum_reg;
    assign frame_status      = status_reg;

endmodule

/* test/humidity_sensor_frame_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_tb: self-checking bench for the reply decoder
// Streams six-byte sensor replies into the decoder and predicts every result
// word from a CRC-8 and scaling model kept inside the bench. Well-formed
// frames with random content, corrupted checksums, restarts mid-frame and
// loose noise bytes are sent under four pacing phases on both channels.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_tb;

    // One byte sent to the decoder.
    typedef struct {
        logic [7:0] data;
        logic       start;
    } reply_byte_t;

    // One decoded reading as the decoder should deliver it.
    typedef struct {
        int   temp;
        int   hum;
        logic status;
    } reading_t;

    localparam int NUM_PHASES   = 4;
    localparam int PHASE_BYTES  = 475;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;  // [7:0] rx_byte
    logic        s_tuser = 1'b0;   // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [14:0] temperature_centi, [28:15] humidity_centi
    logic        m_tuser;          // [0] frame_status

    // Bytes waiting to be sent and readings waiting to arrive.
    reply_byte_t byte_queue[$];
    reading_t    pending_readings[$];
    reply_byte_t next_byte;

    // Decoder state as the bench sees it.
    logic [2:0]  dec_pos     = hsfd_pkg::POS_T_HI;
    logic [7:0]  dec_crc     = hsfd_pkg::CRC_INIT;
    logic [15:0] dec_temp_raw = 16'h0000;
    logic        dec_temp_ok = 1'b0;
    logic [15:0] dec_hum_raw = 16'h0000;

    // Pacing of both channels, in percent of cycles.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatches    = 0;
    int readings_seen = 0;
    int readings_err  = 0;
    int bytes_sent    = 0;

    humidity_sensor_frame_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // MSB-first CRC-8 over one byte.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ hsfd_pkg::CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc8_step(crc8_step(hsfd_pkg::CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // Advance the decoder model by one accepted byte.
    task automatic decode_byte(input logic [7:0] b, input logic start);
        reading_t r;
        logic     hum_ok;
        if (start || dec_pos > hsfd_pkg::POS_H_CRC)
        begin
            dec_pos = hsfd_pkg::POS_T_HI;
            dec_crc = hsfd_pkg::CRC_INIT;
        end
        case (dec_pos)
            hsfd_pkg::POS_T_HI:
            begin
                dec_crc      = crc8_step(hsfd_pkg::CRC_INIT, b);
                dec_temp_raw = {b, 8'h00};
                dec_pos      = hsfd_pkg::POS_T_LO;
            end
            hsfd_pkg::POS_T_LO:
            begin
                dec_crc      = crc8_step(dec_crc, b);
                dec_temp_raw = {dec_temp_raw[15:8], b};
                dec_pos      = hsfd_pkg::POS_T_CRC;
            end
            hsfd_pkg::POS_T_CRC:
            begin
                dec_temp_ok = (dec_crc == b);
                dec_crc     = hsfd_pkg::CRC_INIT;
                dec_pos     = hsfd_pkg::POS_H_HI;
            end
            hsfd_pkg::POS_H_HI:
            begin
                dec_crc     = crc8_step(hsfd_pkg::CRC_INIT, b);
                dec_hum_raw = {b, 8'h00};
                dec_pos     = hsfd_pkg::POS_H_LO;
            end
            hsfd_pkg::POS_H_LO:
            begin
                dec_crc     = crc8_step(dec_crc, b);
                dec_hum_raw = {dec_hum_raw[15:8], b};
                dec_pos     = hsfd_pkg::POS_H_CRC;
            end
            default:
            begin
                // Humidity checksum byte closes the frame.
                hum_ok  = (dec_crc == b);
                dec_crc = hsfd_pkg::CRC_INIT;
                dec_pos = hsfd_pkg::POS_T_HI;
                if (dec_temp_ok && hum_ok)
                begin
                    r.temp   = -4500 + int'((longint'(17500) * dec_temp_raw) / 65535);
                    r.hum    = int'((longint'(10000) * dec_hum_raw) / 65535);
                    r.status = hsfd_pkg::STATUS_OK;
                end
                else
                begin
                    r.temp   = 0;
                    r.hum    = 0;
                    r.status = hsfd_pkg::STATUS_ERR;
                end
                pending_readings.push_back(r);
            end
        endcase
    endtask

    // Driver: presents queued bytes, holds a byte until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tuser);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_byte.data;
                    s_tuser  <= next_byte.start;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input int expv, input int actv);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, expv, actv);
    endtask

    // Compare one delivered word with the oldest predicted reading.
    task automatic check_reading();
        reading_t r;
        readings_seen++;
        if (m_tuser == hsfd_pkg::STATUS_ERR)
            readings_err++;
        if (pending_readings.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected result word %h status %b",
                         $realtime, m_tdata, m_tuser);
        end
        else
        begin
            r = pending_readings.pop_front();
            if (int'($signed(m_tdata[14:0])) != r.temp)
                report_mismatch("temperature", r.temp, int'($signed(m_tdata[14:0])));
            if (int'(m_tdata[28:15]) != r.hum)
                report_mismatch("humidity", r.hum, int'(m_tdata[28:15]));
            if (m_tuser != r.status)
                report_mismatch("status", int'(r.status), int'(m_tuser));
        end
    endtask

    // Monitor: takes result words and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_reading();
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Queue one six-byte reply; a nonzero flip corrupts that checksum byte.
    task automatic add_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                             input logic start, input logic [7:0] t_flip,
                             input logic [7:0] h_flip);
        byte_queue.push_back('{t_raw[15:8], start});
        byte_queue.push_back('{t_raw[7:0], 1'b0});
        byte_queue.push_back('{word_crc(t_raw) ^ t_flip, 1'b0});
        byte_queue.push_back('{h_raw[15:8], 1'b0});
        byte_queue.push_back('{h_raw[7:0], 1'b0});
        byte_queue.push_back('{word_crc(h_raw) ^ h_flip, 1'b0});
    endtask

    // Raw words lean toward the ends of the range now and then.
    function automatic logic [15:0] random_raw();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(16'hFFFE + $urandom_range(1));
            3: return 16'($urandom_range(1));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_flip(input int pct);
        if ($urandom_range(99) < pct)
            return 8'($urandom_range(255, 1));
        return 8'h00;
    endfunction

    // Wait until every byte is sent and every reading has arrived.
    task automatic wait_drained();
        while (byte_queue.size() > 0 || s_tvalid || pending_readings.size() > 0)
            @(posedge clk);
    endtask

    // Stimulus, phase control and final verdict.
    initial
    begin
        int target;
        int n;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames: both range ends, each checksum broken alone,
        // a restart in the middle of a frame, and back-to-back frames.
        add_frame(16'h0000, 16'h0000, 1'b1, 8'h00, 8'h00);
        add_frame(16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 8'h00);
        add_frame(16'h8000, 16'h7FFF, 1'b0, 8'h01, 8'h00);
        byte_queue.push_back('{8'hA5, 1'b1});
        byte_queue.push_back('{8'h5A, 1'b0});
        byte_queue.push_back('{8'hFF, 1'b0});
        add_frame(16'h1234, 16'hFEDC, 1'b1, 8'h00, 8'h80);
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 65 : (phase == 3) ? 24 : 0;
            recv_stall_pct = (phase == 2) ? 65 : (phase == 3) ? 24 : 0;
            target = byte_queue.size() + PHASE_BYTES;
            while (byte_queue.size() < target)
            begin
                n = $urandom_range(99);
                if (n < 80)
                begin
                    add_frame(random_raw(), random_raw(), 1'($urandom_range(1)),
                              random_flip(10), random_flip(10));
                end
                else if (n < 90)
                begin
                    // Truncated reply of random bytes.
                    n = $urandom_range(5, 1);
                    for (int k = 0; k < n; k++)
                        byte_queue.push_back('{8'($urandom), (k == 0) ? 1'b1 : 1'b0});
                end
                else
                begin
                    byte_queue.push_back('{8'($urandom), 1'($urandom_range(1))});
                end
            end
            // The sender pauses here until every reading has come back.
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bytes over four pacing phases; %0d readings checked, %0d flagged bad.",
                 bytes_sent, readings_seen, readings_err);
        $display("Mismatches: %0d, readings still awaited: %0d.",
                 mismatches, pending_readings.size());
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("humidity_sensor_frame_decoder_tb: done, clean");
        else
            $display("humidity_sensor_frame_decoder_tb: done, errors");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(12 * 400000);
        $display("Timeout with %0d readings still awaited.", pending_readings.size());
        $display("humidity_sensor_frame_decoder_tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
rtl/core/hsfd_pkg.sv
rtl/core/hsfd_front.sv
rtl/core/hsfd_queue.sv
rtl/core/hsfd_back.sv
rtl/core/humidity_sensor_frame_decoder.sv
test/humidity_sensor_frame_decoder_tb.sv
